### src/mrd_pkg.sv
// Package for the Modbus RTU response deframer.
// Types, status and register codes, and the byte-wide CRC-16 update.
// No dependencies.
`timescale 1ns / 1ps

package mrd_pkg;

    localparam logic [7:0]  FIXED_READ_CODE  = 8'h03;
    localparam logic [7:0]  FIXED_WRITE_CODE = 8'h10;
    localparam logic [8:0]  WRITE_FRAME_LEN  = 9'd8;
    localparam logic [8:0]  READ_FRAME_BASE  = 9'd5;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'hA001;

    localparam int          ADDR_W = 4;
    localparam logic [1:0]  REG_SLAVE_ADDRESS  = 2'd0;
    localparam logic [1:0]  REG_READ_FUNCTION  = 2'd1;
    localparam logic [1:0]  REG_WRITE_FUNCTION = 2'd2;

    localparam logic [2:0]  ST_INFRAME = 3'd0;
    localparam logic [2:0]  ST_GOOD    = 3'd1;
    localparam logic [2:0]  ST_CRCERR  = 3'd2;
    localparam logic [2:0]  ST_UNKFUNC = 3'd3;
    localparam logic [2:0]  ST_GARBAGE = 3'd4;
    localparam logic [2:0]  ST_FLUSHED = 3'd5;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_FUNC  = 4'b0010,
        PH_COUNT = 4'b0100,
        PH_BODY  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] slave_address;
        logic [7:0] read_function;
        logic [7:0] write_function;
    } t_cfg;

    typedef struct packed {
        logic [2:0] status;
        logic       frame_done;
        logic [8:0] frame_length;
        logic [8:0] byte_index;
        logic [7:0] data_byte;
    } t_result;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### src/mrd_if.sv
// Valid/ready channel interfaces for received bytes and deframer results.
// No dependencies.
`timescale 1ns / 1ps

interface mrd_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface mrd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic       frame_done;
    logic [8:0] frame_length;
    logic [8:0] byte_index;
    logic [7:0] data_byte;

    modport source (output valid, output status, output frame_done, output frame_length,
                    output byte_index, output data_byte, input ready);
    modport sink   (input valid, input status, input frame_done, input frame_length,
                    input byte_index, input data_byte, output ready);
endinterface

### src/modbus_rtu_response_deframer_unit.sv
// Top level of the Modbus RTU response deframer.
// Depends on mrd_pkg, mrd_if, mrd_regs, mrd_core, mrd_outq.
//
//   channel   dir  handshake          payload
//   i_in      in   valid/ready        action, rx_byte
//   o_out     out  valid/ready        status, frame_done, frame_length, byte_index, data_byte
//   apb       in   psel/penable       paddr, pwdata, pwrite -> prdata, pready
//
// One request per cycle while the result buffer has space; each result is registered on acceptance.
// The CRC byte update and the frame state update are computed combinationally in mrd_core.
// A two-entry result buffer keeps input ready while one result is stalled.
// Synchronous active-low reset; no clearing pass.
`timescale 1ns / 1ps

module modbus_rtu_response_deframer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mrd_in_if.sink                      i_in,
    mrd_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mrd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    mrd_pkg::t_cfg    w_cfg;
    mrd_pkg::t_result w_result;
    mrd_pkg::t_result w_out;
    logic             w_space;
    logic             w_accept;

    assign i_in.ready = w_space;
    assign w_accept   = i_in.valid && w_space;

    mrd_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    mrd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_accept  (w_accept),
        .i_action  (i_in.action),
        .i_rx_byte (i_in.rx_byte),
        .o_result  (w_result)
    );

    mrd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_result),
        .o_space (w_space),
        .i_pop   (o_out.ready),
        .o_valid (o_out.valid),
        .o_data  (w_out)
    );

    assign o_out.status       = w_out.status;
    assign o_out.frame_done   = w_out.frame_done;
    assign o_out.frame_length = w_out.frame_length;
    assign o_out.byte_index   = w_out.byte_index;
    assign o_out.data_byte    = w_out.data_byte;

endmodule

### src/mrd_regs.sv
// APB-style configuration registers: slave address and function codes.
// Depends on mrd_pkg.
`timescale 1ns / 1ps

module mrd_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [mrd_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [31:0]                 i_pwdata,
    output logic [31:0]                 o_prdata,
    output logic                        o_pready,
    output mrd_pkg::t_cfg               o_cfg
);

    mrd_pkg::t_cfg r_cfg;
    logic          w_wr;
    logic [1:0]    w_idx;

    assign o_pready = 1'b1;
    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign w_idx    = i_paddr[3:2];
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_address  <= 8'd1;
            r_cfg.read_function  <= 8'd3;
            r_cfg.write_function <= 8'd6;
        end else if (w_wr) begin
            case (w_idx)
                mrd_pkg::REG_SLAVE_ADDRESS:  r_cfg.slave_address  <= i_pwdata[7:0];
                mrd_pkg::REG_READ_FUNCTION:  r_cfg.read_function  <= i_pwdata[7:0];
                mrd_pkg::REG_WRITE_FUNCTION: r_cfg.write_function <= i_pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            mrd_pkg::REG_SLAVE_ADDRESS:  o_prdata = {24'd0, r_cfg.slave_address};
            mrd_pkg::REG_READ_FUNCTION:  o_prdata = {24'd0, r_cfg.read_function};
            mrd_pkg::REG_WRITE_FUNCTION: o_prdata = {24'd0, r_cfg.write_function};
            default:                     o_prdata = 32'd0;
        endcase
    end

endmodule

### src/mrd_core.sv
// Frame state machine with running CRC-16; one byte per accepted request.
// Produces the result for the current request combinationally. Depends on mrd_pkg.
`timescale 1ns / 1ps

module mrd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mrd_pkg::t_cfg    i_cfg,
    input  logic             i_accept,
    input  logic             i_action,
    input  logic [7:0]       i_rx_byte,
    output mrd_pkg::t_result o_result
);

    mrd_pkg::t_phase r_phase, n_phase;
    logic [15:0]     r_crc, n_crc;
    logic [8:0]      r_bytes_seen, n_bytes_seen;
    logic [8:0]      r_exp_len, n_exp_len;
    logic [7:0]      r_last_byte, n_last_byte;
    logic [15:0]     w_crc_upd;
    logic [9:0]      w_seen_p2;

    assign w_crc_upd = mrd_pkg::crc16_byte(r_crc, i_rx_byte);
    assign w_seen_p2 = {1'b0, r_bytes_seen} + 10'd2;

    always_comb begin
        n_phase      = r_phase;
        n_crc        = r_crc;
        n_bytes_seen = r_bytes_seen;
        n_exp_len    = r_exp_len;
        n_last_byte  = r_last_byte;

        o_result.status       = mrd_pkg::ST_INFRAME;
        o_result.frame_done   = 1'b0;
        o_result.frame_length = 9'd0;
        o_result.byte_index   = 9'd0;
        o_result.data_byte    = i_rx_byte;

        if (i_action) begin
            n_phase      = mrd_pkg::PH_HUNT;
            n_crc        = mrd_pkg::CRC_INIT;
            n_bytes_seen = 9'd0;
            n_exp_len    = 9'd0;
            o_result.status    = mrd_pkg::ST_FLUSHED;
            o_result.data_byte = 8'd0;
        end else begin
            o_result.byte_index = r_bytes_seen;
            case (r_phase)
                mrd_pkg::PH_HUNT: begin
                    if (i_rx_byte == i_cfg.slave_address) begin
                        n_crc        = mrd_pkg::crc16_byte(mrd_pkg::CRC_INIT, i_rx_byte);
                        n_bytes_seen = 9'd1;
                        n_phase      = mrd_pkg::PH_FUNC;
                    end else begin
                        o_result.status     = mrd_pkg::ST_GARBAGE;
                        o_result.byte_index = 9'd0;
                    end
                end
                mrd_pkg::PH_FUNC: begin
                    n_crc        = w_crc_upd;
                    n_bytes_seen = 9'd2;
                    if (i_rx_byte == mrd_pkg::FIXED_READ_CODE) begin
                        n_phase = mrd_pkg::PH_COUNT;
                    end else if (i_rx_byte == mrd_pkg::FIXED_WRITE_CODE) begin
                        n_phase   = mrd_pkg::PH_BODY;
                        n_exp_len = mrd_pkg::WRITE_FRAME_LEN;
                    end else if (i_rx_byte == i_cfg.read_function) begin
                        n_phase = mrd_pkg::PH_COUNT;
                    end else if (i_rx_byte == i_cfg.write_function) begin
                        n_phase   = mrd_pkg::PH_BODY;
                        n_exp_len = mrd_pkg::WRITE_FRAME_LEN;
                    end else begin
                        o_result.status = mrd_pkg::ST_UNKFUNC;
                        n_phase         = mrd_pkg::PH_HUNT;
                        n_crc           = mrd_pkg::CRC_INIT;
                        n_bytes_seen    = 9'd0;
                        n_exp_len       = 9'd0;
                    end
                end
                mrd_pkg::PH_COUNT: begin
                    n_exp_len    = mrd_pkg::READ_FRAME_BASE + {1'b0, i_rx_byte};
                    n_crc        = w_crc_upd;
                    n_bytes_seen = 9'd3;
                    n_phase      = mrd_pkg::PH_BODY;
                end
                default: begin
                    if (w_seen_p2 < {1'b0, r_exp_len}) begin
                        n_crc        = w_crc_upd;
                        n_bytes_seen = r_bytes_seen + 9'd1;
                    end else if (w_seen_p2 == {1'b0, r_exp_len}) begin
                        n_last_byte  = i_rx_byte;
                        n_bytes_seen = r_bytes_seen + 9'd1;
                    end else begin
                        o_result.status       = ({i_rx_byte, r_last_byte} == r_crc) ?
                                                mrd_pkg::ST_GOOD : mrd_pkg::ST_CRCERR;
                        o_result.frame_done   = 1'b1;
                        o_result.frame_length = r_exp_len;
                        n_phase      = mrd_pkg::PH_HUNT;
                        n_crc        = mrd_pkg::CRC_INIT;
                        n_bytes_seen = 9'd0;
                        n_exp_len    = 9'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= mrd_pkg::PH_HUNT;
            r_crc        <= mrd_pkg::CRC_INIT;
            r_bytes_seen <= 9'd0;
            r_exp_len    <= 9'd0;
            r_last_byte  <= 8'd0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_crc        <= n_crc;
            r_bytes_seen <= n_bytes_seen;
            r_exp_len    <= n_exp_len;
            r_last_byte  <= n_last_byte;
        end
    end

endmodule

### src/mrd_outq.sv
// Two-entry result buffer: a ring of two entries with read and write pointers.
// Depends on mrd_pkg.
`timescale 1ns / 1ps

module mrd_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mrd_pkg::t_result i_data,
    output logic             o_space,
    input  logic             i_pop,
    output logic             o_valid,
    output mrd_pkg::t_result o_data
);

    mrd_pkg::t_result r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic             w_pop;

    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (w_pop)  r_rptr <= ~r_rptr;
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### src/mrd_checker.sv
// Port-level assertions for the deframer, bound to the top level.
// Depends on mrd_pkg and modbus_rtu_response_deframer_unit.
`timescale 1ns / 1ps

module mrd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [2:0] i_status,
    input logic       i_frame_done,
    input logic [8:0] i_frame_length,
    input logic [8:0] i_byte_index,
    input logic [7:0] i_data_byte
);

    a_done_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_frame_done == ((i_status == mrd_pkg::ST_GOOD) ||
                                      (i_status == mrd_pkg::ST_CRCERR))))
        else $error("frame_done disagrees with status");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_frame_done) |-> (i_frame_length == 9'd0))
        else $error("frame_length set without frame_done");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_frame_done) |-> ((i_frame_length >= 9'd5) && (i_frame_length <= 9'd260)
                                       && (i_byte_index + 9'd1 == i_frame_length)))
        else $error("completed frame length out of range");

    a_flush_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_status == mrd_pkg::ST_FLUSHED)) |->
            ((i_byte_index == 9'd0) && (i_data_byte == 8'd0)))
        else $error("flush result not cleared");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_status) && $stable(i_byte_index)
                                   && $stable(i_data_byte)))
        else $error("stalled result changed");

endmodule

bind modbus_rtu_response_deframer_unit mrd_checker u_mrd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_out.valid),
    .i_ready        (o_out.ready),
    .i_status       (o_out.status),
    .i_frame_done   (o_out.frame_done),
    .i_frame_length (o_out.frame_length),
    .i_byte_index   (o_out.byte_index),
    .i_data_byte    (o_out.data_byte)
);
